// ----- rtl/pbnn_pkg.sv -----
// ----------------------------------------------------------------------------
// pbnn_pkg
// Shared types and constants of the page bitmap nearest-neighbour scaler:
// register indexes, item codes, divider widths and the divider handshake.
// ----------------------------------------------------------------------------
package pbnn_pkg;

  // default store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // field widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned SH_W     = 7;
  localparam int unsigned SW_W     = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BIT_IDX_W = $clog2(PIX_W);

  // divider: numerator (2*pos*src + src), denominator 2*dst
  localparam int unsigned NUM_W      = 16;
  localparam int unsigned DEN_W      = 9;
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_CYC    = NUM_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYC);

  // register reset values
  localparam logic [SH_W-1:0] SRC_H_RST = 7'd32;
  localparam logic [SW_W-1:0] SRC_W_RST = 8'd24;
  localparam logic [SH_W-1:0] DST_H_RST = 7'd48;
  localparam logic [SW_W-1:0] DST_W_RST = 8'd36;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_HEIGHT = 8'd0,
    REG_SRC_WIDTH  = 8'd1,
    REG_DST_HEIGHT = 8'd2,
    REG_DST_WIDTH  = 8'd3
  } cfg_reg_e;

  // item kinds
  typedef enum logic {
    KIND_STORE   = 1'b0,
    KIND_COMPUTE = 1'b1
  } kind_e;

  // result status codes
  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_OUTSIDE = 1'b1
  } status_e;

  // divider request and response
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/pbnn_mem.sv -----
// ----------------------------------------------------------------------------
// pbnn_mem
// Source bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbnn_mem import pbnn_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [PIX_W-1:0]  rdata_o
);

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pbnn_div.sv -----
// ----------------------------------------------------------------------------
// pbnn_div
// Restoring unsigned divider, several quotient bits per cycle. Used for the
// rounded position mapping of the column and of each row.
// ----------------------------------------------------------------------------
module pbnn_div import pbnn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;

  logic [NUM_W-1:0]     num_v;
  logic [DEN_W-1:0]     rem_v;
  logic [DEN_W:0]       trial;

  // a few restoring steps per cycle
  always_comb begin
    num_v = num_q;
    rem_v = rem_q;
    trial = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_v, num_v[NUM_W-1]};
      num_v = {num_v[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_v    = DEN_W'(trial - {1'b0, den_q});
        num_v[0] = 1'b1;
      end else begin
        rem_v = trial[DEN_W-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.valid) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      num_q <= req_i.numer;
      den_q <= req_i.denom;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= num_v;
      rem_q <= rem_v;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ----- rtl/page_bitmap_nearest_neighbor_scaler_core.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_nearest_neighbor_scaler_core
// Rounded nearest-neighbour scaler for 1-bit bitmaps in page format.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------
//   item     | in        | start_i, busy_o         | kind, page, column, pixel_byte
//   result   | out       | done_o (one-cycle beat) | scaled_byte, status
//   config   | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// A store beat leaves busy_o low. A compute beat outside the destination
// gives its result in the next cycle without going busy. Any other compute
// beat keeps busy_o high through one column and eight row divisions in the
// shared divider (4 bits a cycle) and eight source memory reads; each read
// overlaps the next division, the last one the drain state. The result beat
// appears in the same cycle as busy_o falls; the receiver cannot stall it.
// Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module page_bitmap_nearest_neighbor_scaler_core import pbnn_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 kind_i,
  input  logic [PAGE_W-1:0]    page_i,
  input  logic [COL_W-1:0]     column_i,
  input  logic [PIX_W-1:0]     pixel_byte_i,
  // result channel
  output logic                 done_o,
  output logic [PIX_W-1:0]     scaled_byte_o,
  output logic                 status_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i
);

  localparam int unsigned STORE_PAGES = (MAX_HEIGHT + 7) / 8;
  localparam int unsigned STORE_DEPTH = STORE_PAGES * MAX_WIDTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(PIX_W - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COL   = 4'b0010,
    S_ROW   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [SH_W-1:0]      src_h_q;
  logic [SW_W-1:0]      src_w_q;
  logic [SH_W-1:0]      dst_h_q;
  logic [SW_W-1:0]      dst_w_q;
  logic [PAGE_W-1:0]    page_q, page_d;
  logic [NUM_W-1:0]     src_col_q, src_col_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [PIX_W-1:0]     acc_q, acc_d, acc_merged;
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [2:0]           rd_sel_q, rd_sel_d;
  logic [BIT_IDX_W-1:0] rd_bit_q, rd_bit_d;
  logic                 done_q, done_d;
  logic [PIX_W-1:0]     scaled_q, scaled_d;
  logic                 status_q, status_d;

  logic                 in_accept;
  logic                 is_compute;
  logic                 st_we;
  logic [ADDR_W-1:0]    st_addr;
  logic                 mem_re;
  logic [ADDR_W-1:0]    rd_addr;
  logic [PIX_W-1:0]     rd_data;

  logic [7:0]           tgt_pg_sum;
  logic [4:0]           tgt_pg_cnt;
  logic                 outside;
  logic [COL_W+SW_W-1:0] col_prod;
  logic [NUM_W-1:0]     col_numer;
  logic [DEN_W-1:0]     col_denom;
  logic [BIT_IDX_W-1:0] row_bit;
  logic [PAGE_W+BIT_IDX_W+SH_W-1:0] row_prod;
  logic [NUM_W-1:0]     row_numer;
  logic [DEN_W-1:0]     row_denom;
  logic [NUM_W-1:0]     row_src;
  logic                 row_ok;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // handshakes
  assign in_accept   = start_i && !busy_o;
  assign is_compute  = (kind_e'(kind_i) == KIND_COMPUTE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_h_q <= SRC_H_RST;
      src_w_q <= SRC_W_RST;
      dst_h_q <= DST_H_RST;
      dst_w_q <= DST_W_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i[SH_W-1:0];
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i[SW_W-1:0];
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i[SH_W-1:0];
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i[SW_W-1:0];
        default: ;
      endcase
    end
  end

  // store beats go straight into the memory
  assign st_we   = in_accept && !is_compute
                   && (32'(page_i) < STORE_PAGES) && (32'(column_i) < MAX_WIDTH);
  assign st_addr = ADDR_W'(32'(page_i) * MAX_WIDTH + 32'(column_i));

  pbnn_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_addr),
    .wdata_i (pixel_byte_i),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pbnn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // destination bounds
  assign tgt_pg_sum = {1'b0, dst_h_q} + 8'd7;
  assign tgt_pg_cnt = tgt_pg_sum[7:3];
  assign outside    = ({1'b0, column_i} >= dst_w_q)
                      || ({2'b0, page_i} >= tgt_pg_cnt);

  // column mapping operands
  assign col_prod  = column_i * src_w_q;
  assign col_numer = NUM_W'({col_prod, 1'b0}) + NUM_W'(src_w_q);
  assign col_denom = {dst_w_q, 1'b0};

  // row mapping operands
  assign row_bit   = (state_q == S_COL) ? '0 : bit_q + 1'b1;
  assign row_prod  = {page_q, row_bit} * src_h_q;
  assign row_numer = NUM_W'({row_prod, 1'b0}) + NUM_W'(src_h_q);
  assign row_denom = {1'b0, dst_h_q, 1'b0};

  // source pixel lookup for a finished row division
  assign row_src = div_rsp.quot;
  assign row_ok  = (row_src < NUM_W'(src_h_q)) && (src_col_q < NUM_W'(src_w_q))
                   && (32'(row_src) < MAX_HEIGHT) && (32'(src_col_q) < MAX_WIDTH);
  assign rd_addr = ADDR_W'(32'(row_src >> 3) * MAX_WIDTH + 32'(src_col_q));

  // merge the bit returned by the memory
  always_comb begin
    acc_merged = acc_q;
    if (rd_pend_q) begin
      acc_merged[rd_bit_q] = rd_ok_q && rd_data[rd_sel_q];
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    page_d        = page_q;
    src_col_d     = src_col_q;
    bit_d         = bit_q;
    acc_d         = acc_merged;
    rd_pend_d     = 1'b0;
    rd_ok_d       = rd_ok_q;
    rd_sel_d      = rd_sel_q;
    rd_bit_d      = rd_bit_q;
    done_d        = 1'b0;
    scaled_d      = scaled_q;
    status_d      = status_q;
    mem_re        = 1'b0;
    div_req.valid = 1'b0;
    div_req.numer = row_numer;
    div_req.denom = row_denom;
    case (state_q)
      S_IDLE: begin
        if (in_accept && is_compute) begin
          page_d = page_i;
          acc_d  = '0;
          if (outside) begin
            done_d   = 1'b1;
            scaled_d = '0;
            status_d = STATUS_OUTSIDE;
          end else begin
            div_req.valid = 1'b1;
            div_req.numer = col_numer;
            div_req.denom = col_denom;
            state_d       = S_COL;
          end
        end
      end
      S_COL: begin
        if (div_rsp.done) begin
          src_col_d     = div_rsp.quot;
          bit_d         = '0;
          div_req.valid = 1'b1;
          state_d       = S_ROW;
        end
      end
      S_ROW: begin
        if (div_rsp.done) begin
          mem_re    = row_ok;
          rd_pend_d = 1'b1;
          rd_ok_d   = row_ok;
          rd_sel_d  = row_src[2:0];
          rd_bit_d  = bit_q;
          if (bit_q == BIT_LAST) begin
            state_d = S_DRAIN;
          end else begin
            bit_d         = bit_q + 1'b1;
            div_req.valid = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        done_d   = 1'b1;
        scaled_d = acc_merged;
        status_d = STATUS_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_q     <= '0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_q     <= bit_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    src_col_q <= src_col_d;
    acc_q     <= acc_d;
    rd_ok_q   <= rd_ok_d;
    rd_sel_q  <= rd_sel_d;
    rd_bit_q  <= rd_bit_d;
    scaled_q  <= scaled_d;
    status_q  <= status_d;
  end

  assign done_o        = done_q;
  assign scaled_byte_o = scaled_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  // divider only answers while a mapping is in flight
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_COL || state_q == S_ROW))
    else $error("divider result outside a mapping phase");

  // a source read is pending only while the row bits are gathered
  a_rd_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_ROW || state_q == S_DRAIN))
    else $error("source read pending in wrong phase");

  // the drain cycle always ends in a result beat and idle
  a_drain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (done_q && state_q == S_IDLE))
    else $error("drain did not deliver a result");

  // no store may land while a compute item reads the memory
  a_no_store_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q || mem_re) |-> !st_we)
    else $error("store overlaps source read");

  // an outside result carries an all-zero byte
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STATUS_OUTSIDE) |-> (scaled_q == '0))
    else $error("outside result with non-zero byte");
`endif

endmodule
